### rtl/pulse_peak_ratio_collector_assert.svh
// ----------------------------------------------------------------------------
// Pulse peak ratio collector: assertion macros
// Short forms for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PULSE_PEAK_RATIO_COLLECTOR_ASSERT_SVH
`define PULSE_PEAK_RATIO_COLLECTOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PPRC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("pulse_peak_ratio_collector: check failed");

// next-cycle implication, checked out of reset
`define PPRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("pulse_peak_ratio_collector: check failed");

`endif

### rtl/pprc_pkg.sv
// ----------------------------------------------------------------------------
// pprc_pkg
// Widths, limits and register indexes of the pulse peak ratio collector.
// ----------------------------------------------------------------------------
`default_nettype none

package pprc_pkg;

	localparam int MAX_BEATS = 16;

	localparam int GAP_W     = 10;
	localparam int BEATS_W   = 5;
	localparam int CNT_W     = 5;
	localparam int LEVEL_W   = 16;
	localparam int POS_W     = 16;
	localparam int RATIO_W   = 24;
	localparam int TOTAL_W   = RATIO_W + $clog2(MAX_BEATS);
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 10;

	// shared divider: 32-bit dividend, 16-bit divisor, one quotient bit a cycle
	localparam int DIV_N_W   = 32;
	localparam int DIV_D_W   = 16;
	localparam int DIV_CNT_W = $clog2(DIV_N_W);

	localparam logic [GAP_W-1:0]   GAP_MAX       = {GAP_W{1'b1}};
	localparam logic [GAP_W-1:0]   MIN_GAP_RESET = GAP_W'(40);
	localparam logic [GAP_W-1:0]   GAP_RESET     = GAP_W'((40 * 3) / 4);
	localparam logic [BEATS_W-1:0] BEATS_RESET   = BEATS_W'(16);
	localparam logic [RATIO_W-1:0] RATIO_MAX     = {RATIO_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_MIN_GAP      = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BEATS_IN_USE = CFG_IDX_W'(1);

	localparam logic OP_SAMPLE  = 1'b0;
	localparam logic OP_RESTART = 1'b1;

endpackage

`default_nettype wire

### rtl/pulse_peak_ratio_collector.sv
// ----------------------------------------------------------------------------
// Pulse peak ratio collector
// Collects one |ac|/dc ratio (unsigned Q8.16) per beat from pulse-oximeter
// samples and reports fill state, peak count, mean ratio and last peak
// position for every item. One restoring divider, one quotient bit per cycle,
// serves both the ratio and the average: a sample item passes through the
// ratio division, an update step, an average step, the average division and
// a done step before the next transfer. The ratio division is skipped for
// zero dc and the average division while the store is empty, and a restart
// skips both. in_ready is high only while the sequencer is idle; a finished
// result waits in the output register and the next item can be taken
// meanwhile. Only the most recent peak is ever read back, so its ratio and
// position are held in registers.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pulse_peak_ratio_collector_assert.svh"

module pulse_peak_ratio_collector import pprc_pkg::*; (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	// configuration
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [CFG_DATA_W-1:0]        cfg_data,
	// input items
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic                         opcode,
	input  wire logic [LEVEL_W-1:0]           dc_level,
	input  wire logic signed [LEVEL_W-1:0]    ac_level,
	input  wire logic [POS_W-1:0]             sample_position,
	// results
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic                              store_full,
	output logic [CNT_W-1:0]                  peak_count,
	output logic [RATIO_W-1:0]                average_ratio,
	output logic [POS_W-1:0]                  last_peak_position
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RDIV = 3'd1;
	localparam logic [2:0] ST_UPD  = 3'd2;
	localparam logic [2:0] ST_AVG  = 3'd3;
	localparam logic [2:0] ST_ADIV = 3'd4;
	localparam logic [2:0] ST_DONE = 3'd5;

	logic [2:0]            state_q;

	logic [GAP_W-1:0]      min_gap_q;
	logic [BEATS_W-1:0]    beats_q;

	logic                  op_q;
	logic                  dc_zero_q;
	logic [POS_W-1:0]      pos_q;

	logic [GAP_W-1:0]      gap_q;
	logic [CNT_W-1:0]      count_q;
	logic [TOTAL_W-1:0]    total_q;
	logic [RATIO_W-1:0]    last_ratio_q;
	logic [POS_W-1:0]      last_pos_q;

	// divider
	logic [DIV_N_W-1:0]    quo_q;
	logic [DIV_D_W-1:0]    rem_q;
	logic [DIV_D_W-1:0]    div_q;
	logic [DIV_CNT_W-1:0]  step_q;
	logic [DIV_D_W:0]      rem_sh;
	logic [DIV_D_W+1:0]    diff;
	logic                  q_bit;

	logic                  out_valid_q;
	logic                  store_full_q;
	logic [CNT_W-1:0]      peak_count_q;
	logic [RATIO_W-1:0]    average_q;
	logic [POS_W-1:0]      last_peak_q;

	logic [LEVEL_W-1:0]    ac_mag;
	logic [CNT_W-1:0]      beats_eff;
	logic [GAP_W-1:0]      gap_inc;
	logic [RATIO_W-1:0]    ratio;
	logic [GAP_W+1:0]      gap_x3;
	logic                  div_last;
	logic                  out_load;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign ac_mag = ac_level[LEVEL_W-1] ? LEVEL_W'(~ac_level + 1'b1) : LEVEL_W'(ac_level);

	always_comb begin
		if (beats_q == '0)
			beats_eff = CNT_W'(1);
		else if (CNT_W'(beats_q) > CNT_W'(MAX_BEATS))
			beats_eff = CNT_W'(MAX_BEATS);
		else
			beats_eff = CNT_W'(beats_q);
	end

	assign gap_inc = (gap_q < GAP_MAX) ? gap_q + 1'b1 : gap_q;
	assign gap_x3  = {1'b0, min_gap_q, 1'b0} + {2'b00, min_gap_q};

	// saturating ratio from the finished quotient
	assign ratio = (dc_zero_q || (|quo_q[DIV_N_W-1:RATIO_W])) ? RATIO_MAX
		: quo_q[RATIO_W-1:0];

	// one restoring step
	assign rem_sh   = {rem_q, quo_q[DIV_N_W-1]};
	assign diff     = {1'b0, rem_sh} - {2'b00, div_q};
	assign q_bit    = ~diff[DIV_D_W+1];
	assign div_last = (step_q == DIV_CNT_W'(DIV_N_W - 1));

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_gap_q <= MIN_GAP_RESET;
			beats_q   <= BEATS_RESET;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == REG_MIN_GAP)
				min_gap_q <= cfg_data;
			else if (cfg_index == REG_BEATS_IN_USE)
				beats_q <= cfg_data[BEATS_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			gap_q   <= GAP_RESET;
			count_q <= '0;
			total_q <= '0;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						step_q <= '0;
						if (opcode == OP_RESTART)
							state_q <= ST_UPD;
						else if (dc_level == '0)
							state_q <= ST_UPD;
						else
							state_q <= ST_RDIV;
					end
				end
				ST_RDIV: begin
					step_q <= step_q + 1'b1;
					if (div_last)
						state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_AVG;
					if (op_q == OP_RESTART) begin
						gap_q   <= gap_x3[GAP_W+1:2];
						count_q <= '0;
						total_q <= '0;
					end else if (gap_inc >= min_gap_q && count_q < beats_eff) begin
						total_q <= total_q + TOTAL_W'(ratio);
						count_q <= count_q + 1'b1;
						gap_q   <= '0;
					end else if (gap_inc < min_gap_q && count_q != '0 &&
					             last_ratio_q < ratio) begin
						total_q <= total_q - TOTAL_W'(last_ratio_q) + TOTAL_W'(ratio);
						gap_q   <= '0;
					end else begin
						gap_q <= gap_inc;
					end
				end
				ST_AVG: begin
					step_q <= '0;
					if (count_q == '0)
						state_q <= ST_DONE;
					else
						state_q <= ST_ADIV;
				end
				ST_ADIV: begin
					step_q <= step_q + 1'b1;
					if (div_last)
						state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// item latch, last peak and divider datapath
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q      <= opcode;
			dc_zero_q <= (dc_level == '0);
			pos_q     <= sample_position;
			quo_q     <= {ac_mag, {(DIV_N_W-LEVEL_W){1'b0}}};
			div_q     <= dc_level;
			rem_q     <= '0;
		end else if (state_q == ST_RDIV || state_q == ST_ADIV) begin
			quo_q <= {quo_q[DIV_N_W-2:0], q_bit};
			rem_q <= q_bit ? diff[DIV_D_W-1:0] : rem_sh[DIV_D_W-1:0];
		end else if (state_q == ST_AVG) begin
			quo_q <= DIV_N_W'(total_q);
			div_q <= DIV_D_W'(count_q);
			rem_q <= '0;
		end

		if (state_q == ST_UPD && op_q == OP_SAMPLE) begin
			if ((gap_inc >= min_gap_q && count_q < beats_eff) ||
			    (gap_inc < min_gap_q && count_q != '0 && last_ratio_q < ratio)) begin
				last_ratio_q <= ratio;
				last_pos_q   <= pos_q;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (out_load)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			store_full_q <= (count_q >= beats_eff);
			peak_count_q <= count_q;
			if (count_q == '0) begin
				average_q   <= '0;
				last_peak_q <= '0;
			end else begin
				average_q   <= quo_q[RATIO_W-1:0];
				last_peak_q <= last_pos_q;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign store_full         = store_full_q;
	assign peak_count         = peak_count_q;
	assign average_ratio      = average_q;
	assign last_peak_position = last_peak_q;

	`PPRC_ASSERT_NOW(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_W'(MAX_BEATS))
	`PPRC_ASSERT_NEXT(a_busy_after_transfer, clk, arst_n, in_valid && in_ready, !in_ready)
	`PPRC_ASSERT_NOW(a_empty_result, clk, arst_n, out_valid && peak_count == '0,
		average_ratio == '0 && last_peak_position == '0)
	`PPRC_ASSERT_NOW(a_full_flag, clk, arst_n, out_valid && peak_count == '0, !store_full)

endmodule

`default_nettype wire
